### sv/nps_pkg.sv
// Shared constants, types and codes of the priority scheduler.
`default_nettype none

package nps_pkg;

   // Table capacity and derived widths
   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);

   // Field widths
   localparam int ID_W     = 16;
   localparam int BURST_W  = 16;
   localparam int ARRIVE_W = 16;
   localparam int PRIO_W   = 8;
   localparam int TIME_W   = 32;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 48;

   // Item kinds on the request tuser
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_START = 1'b1;

   // One task table entry, id in the lowest bits
   typedef struct packed {
      logic [PRIO_W-1:0]   prio;
      logic [ARRIVE_W-1:0] arrival;
      logic [BURST_W-1:0]  burst;
      logic [ID_W-1:0]     id;
   } entry_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

   // Control from the sequencer to the selection unit
   typedef struct packed {
      logic             clear;
      logic             valid;
      logic             pending;
      logic [IDX_W-1:0] idx;
   } scan_ctl_type;

   // Outcome of one table scan
   typedef struct packed {
      logic                found;
      logic [IDX_W-1:0]    best_idx;
      logic [PRIO_W-1:0]   best_prio;
      logic [ID_W-1:0]     best_id;
      logic [BURST_W-1:0]  best_burst;
      logic [ARRIVE_W-1:0] earliest;
   } sel_type;

endpackage

`default_nettype wire

### sv/nonpreemptive_priority_scheduler.sv
// Top level of the non-preemptive priority scheduler.
//
//  port group  | dir | tdata (low bit up)                          | side band
//  req_*       | in  | task_id, burst_time, arrival_time, task_prio | tuser = kind
//  rsp_*       | out | done_id, finish_time                         | tlast = last
//
// A load writes the next table entry; a start walks the task table in RAM once per round
// (one RAM read a cycle, then the registered read, then the decision).
// A round in which nothing has arrived moves time to the earliest arrival and
// costs one more walk. Reset clears the pending bits, task count and time; the
// table RAM is not cleared. The decision stalls while the result register is full.
`default_nettype none

module nonpreemptive_priority_scheduler
   import nps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // task_id[15:0], burst_time[31:16], arrival_time[47:32], task_priority[55:48]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // kind[0]
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // done_id[15:0], finish_time[47:16]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     left_ff, left_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic [MAX_TASKS-1:0] pending_ff, pending_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [TIME_W-1:0]    rsp_time_ff, rsp_time_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_transfer;
   logic                 rsp_load;
   logic                 slot_free;
   logic                 wr_en;
   logic                 rd_en;
   entry_type            wr_entry;
   entry_type            rd_entry;
   scan_ctl_type         scan_ctl;
   logic                 scan_clear;
   sel_type              sel;
   logic [TIME_W:0]      finish_sum;
   logic [TIME_W-1:0]    finish_sat;

   assign req_tready   = (state_ff == ST_IDLE);
   assign req_transfer = req_tvalid && req_tready;
   assign slot_free    = !rsp_valid_ff || rsp_tready;

   // Pack the request fields into a table entry
   assign wr_entry.id      = req_tdata[15:0];
   assign wr_entry.burst   = req_tdata[31:16];
   assign wr_entry.arrival = req_tdata[47:32];
   assign wr_entry.prio    = req_tdata[55:48];

   // Saturating finish time of the winner
   assign finish_sum = {1'b0, time_ff} + {{(TIME_W+1-BURST_W){1'b0}}, sel.best_burst};
   assign finish_sat = finish_sum[TIME_W] ? {TIME_W{1'b1}} : finish_sum[TIME_W-1:0];

   nps_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_TASKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_entry)
   );

   assign scan_ctl.clear   = scan_clear;
   assign scan_ctl.valid   = rd_valid_ff;
   assign scan_ctl.pending = pending_ff[rd_idx_ff];
   assign scan_ctl.idx     = rd_idx_ff;

   nps_select u_select (
      .clock        (clock),
      .reset        (reset),
      .scan_ctl     (scan_ctl),
      .rd_entry     (rd_entry),
      .current_time (time_ff),
      .sel          (sel)
   );

   // Sequencer: load, walk the table, decide and emit
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      left_in     = left_ff;
      issue_in    = issue_ff;
      pending_in  = pending_ff;
      time_in     = time_ff;
      rd_valid_in = 1'b0;
      rd_idx_in   = rd_idx_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      scan_clear  = 1'b0;
      rsp_load    = 1'b0;
      rsp_id_in   = rsp_id_ff;
      rsp_time_in = rsp_time_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_transfer) begin
               if (req_tuser == KIND_LOAD) begin
                  // drop the load when the table is full
                  if (count_ff < CNT_W'(MAX_TASKS)) begin
                     wr_en                            = 1'b1;
                     pending_in[count_ff[IDX_W-1:0]]  = 1'b1;
                     count_in                         = count_ff + 1'b1;
                  end
               end else begin
                  time_in = '0;
                  if (count_ff != '0) begin
                     left_in    = count_ff;
                     issue_in   = '0;
                     scan_clear = 1'b1;
                     state_in   = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff < count_ff) begin
               rd_en       = 1'b1;
               rd_valid_in = 1'b1;
               rd_idx_in   = issue_ff[IDX_W-1:0];
               issue_in    = issue_ff + 1'b1;
            end else if (!rd_valid_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!sel.found) begin
               // nothing ready: jump to the earliest arrival and rescan
               time_in    = {{(TIME_W-ARRIVE_W){1'b0}}, sel.earliest};
               issue_in   = '0;
               scan_clear = 1'b1;
               state_in   = ST_SCAN;
            end else if (slot_free) begin
               rsp_load                = 1'b1;
               rsp_id_in               = sel.best_id;
               rsp_time_in             = finish_sat;
               rsp_last_in             = (left_ff == CNT_W'(1));
               time_in                 = finish_sat;
               pending_in[sel.best_idx] = 1'b0;
               left_in                 = left_ff - 1'b1;
               if (left_ff == CNT_W'(1)) begin
                  // run complete: empty the table
                  pending_in = '0;
                  count_in   = '0;
                  state_in   = ST_IDLE;
               end else begin
                  issue_in   = '0;
                  scan_clear = 1'b1;
                  state_in   = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result register: load on a decision, drop on a transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         left_ff      <= '0;
         issue_ff     <= '0;
         pending_ff   <= '0;
         time_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         issue_ff     <= issue_in;
         pending_ff   <= pending_in;
         time_ff      <= time_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff   <= rd_idx_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_time_ff <= rsp_time_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_time_ff, rsp_id_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Checks on the sequencer
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TASKS))
      else $error("task count beyond capacity");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (issue_ff <= count_ff))
      else $error("scan read beyond loaded entries");

   a_busy_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (left_ff != '0))
      else $error("run active with no task left");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> ((count_ff == '0) && (pending_ff == '0)))
      else $error("table not emptied after final completion");

   a_win_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE && sel.found) |-> pending_ff[sel.best_idx])
      else $error("winner is not a pending entry");

endmodule

`default_nettype wire

### sv/nps_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module nps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### sv/nps_select.sv
// Selection unit: folds the scanned table entries into the round winner.
`default_nettype none

module nps_select
   import nps_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire scan_ctl_type      scan_ctl,
   input  wire entry_type         rd_entry,
   input  wire logic [TIME_W-1:0] current_time,
   output sel_type                sel
);

   sel_type sel_ff, sel_in;
   logic    arrived;

   assign arrived = ({{(TIME_W-ARRIVE_W){1'b0}}, rd_entry.arrival} <= current_time);

   // Keep the best arrived entry and the earliest pending arrival
   always_comb begin
      sel_in = sel_ff;
      if (scan_ctl.clear) begin
         sel_in.found    = 1'b0;
         sel_in.earliest = '1;
      end else if (scan_ctl.valid && scan_ctl.pending) begin
         if (arrived) begin
            if (!sel_ff.found || (rd_entry.prio > sel_ff.best_prio)) begin
               sel_in.found      = 1'b1;
               sel_in.best_idx   = scan_ctl.idx;
               sel_in.best_prio  = rd_entry.prio;
               sel_in.best_id    = rd_entry.id;
               sel_in.best_burst = rd_entry.burst;
            end
         end else if (rd_entry.arrival < sel_ff.earliest) begin
            sel_in.earliest = rd_entry.arrival;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= '0;
      end else begin
         sel_ff <= sel_in;
      end
   end

   assign sel = sel_ff;

endmodule

`default_nettype wire

### dv/nps_checker.sv
// Checker that predicts the scheduler's completion stream and compares it with the block.
`timescale 1ns / 100ps

module nps_checker
   import nps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   // task_id[15:0], burst_time[31:16], arrival_time[47:32], task_priority[55:48]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // kind[0]
   input  wire logic                  req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // done_id[15:0], finish_time[47:16]
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  rsp_tlast,
   output int                         fail_count,
   output int                         results_due
);

   // One predicted completion
   typedef struct {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] finish;
      logic              last;
   } completion_type;

   // Private copy of the task table and run state
   entry_type            task_table [MAX_TASKS];
   logic [MAX_TASKS-1:0] task_waiting;
   int unsigned          tasks_loaded;
   completion_type       completions_due [$];

   initial begin
      fail_count  = 0;
      results_due = 0;
   end

   // Run the whole schedule for the loaded table and queue every completion
   task automatic schedule_tasks();
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] earliest;
      logic [TIME_W:0]   sum;
      completion_type    done;
      int                best;
      int                remaining;
      now       = '0;
      remaining = 0;
      for (int i = 0; i < MAX_TASKS; i++)
         if (i < tasks_loaded && task_waiting[i]) remaining++;
      while (remaining > 0) begin
         best     = -1;
         earliest = '1;
         // pick the highest ready priority, first loaded on a tie
         for (int i = 0; i < MAX_TASKS; i++) begin
            if (task_waiting[i]) begin
               if (TIME_W'(task_table[i].arrival) <= now) begin
                  if (best < 0 || task_table[i].prio > task_table[best].prio) best = i;
               end else if (TIME_W'(task_table[i].arrival) < earliest) begin
                  earliest = TIME_W'(task_table[i].arrival);
               end
            end
         end
         if (best < 0) begin
            // nothing ready: jump to the next arrival
            now = earliest;
         end else begin
            sum  = {1'b0, now} + (TIME_W + 1)'(task_table[best].burst);
            now  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            task_waiting[best] = 1'b0;
            remaining--;
            done.id     = task_table[best].id;
            done.finish = now;
            done.last   = (remaining == 0);
            completions_due.insert(completions_due.size(), done);
         end
      end
      task_waiting = '0;
      tasks_loaded = 0;
   endtask

   always @(posedge clock) begin
      entry_type      item;
      completion_type due;
      if (reset) begin
         task_waiting = '0;
         tasks_loaded = 0;
         completions_due.delete();
      end else begin
         // take a request transfer: store a load or run the schedule
         if (req_tvalid && req_tready) begin
            item = req_tdata;
            if (req_tuser == KIND_LOAD) begin
               if (tasks_loaded < MAX_TASKS) begin
                  task_table[tasks_loaded]   = item;
                  task_waiting[tasks_loaded] = 1'b1;
                  tasks_loaded++;
               end
            end else begin
               schedule_tasks();
            end
         end
         // compare a result transfer with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (completions_due.size() == 0) begin
               $error("unexpected result: done_id %0h finish_time %0h last %0b",
                      rsp_tdata[ID_W-1:0], rsp_tdata[ID_W +: TIME_W], rsp_tlast);
               fail_count++;
            end else begin
               due = completions_due.pop_front();
               if (rsp_tdata[ID_W-1:0] !== due.id) begin
                  $error("done_id: expected %0h, got %0h", due.id, rsp_tdata[ID_W-1:0]);
                  fail_count++;
               end
               if (rsp_tdata[ID_W +: TIME_W] !== due.finish) begin
                  $error("finish_time: expected %0h, got %0h",
                         due.finish, rsp_tdata[ID_W +: TIME_W]);
                  fail_count++;
               end
               if (rsp_tlast !== due.last) begin
                  $error("last: expected %0b, got %0b", due.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
      results_due <= completions_due.size();
   end

endmodule

### dv/testbench.sv
// Top of the scheduler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
   import nps_pkg::*;

   localparam int RUN_LIMIT    = 500000;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 60;
   localparam int PHASE_ITEMS  = 72;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = KIND_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   int   fail_count;
   int   results_due;
   int   tx_idle_pct  = 0;
   int   rx_idle_pct  = 0;
   logic long_hold_go = 1'b0;
   int   cycle_count  = 0;

   nonpreemptive_priority_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   nps_checker completion_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Task with content biased towards ties, early arrivals and short bursts
   function automatic entry_type random_task();
      entry_type t;
      t.id    = 16'($urandom);
      t.burst = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 12)) : 16'($urandom);
      t.prio  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      case ($urandom_range(0, 3))
         0:       t.arrival = '0;
         1:       t.arrival = 16'($urandom);
         default: t.arrival = 16'($urandom_range(0, 24));
      endcase
      return t;
   endfunction

   // Offer one item after a random gap and hold it until the transfer
   task automatic offer(input logic kind, input entry_type fields);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= fields;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait until every predicted completion has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   initial begin : stimulus
      entry_type fields;
      int        counted;
      int        batch;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      tx_idle_pct = 21;
      rx_idle_pct = 88;

      // start on an empty table, every ignored field bit set
      offer(KIND_START, '1);
      // all-ones task arrives last; zero burst and a priority tie at time zero
      offer(KIND_LOAD, '1);
      offer(KIND_LOAD, '0);
      offer(KIND_LOAD, entry_type'{prio: '0, arrival: '0, burst: 16'd3, id: 16'd5});
      offer(KIND_START, '0);
      // overfill the table so the final load is dropped
      for (int i = 0; i <= MAX_TASKS; i++) begin
         fields         = random_task();
         fields.id      = 16'(i);
         fields.arrival = 16'(8 * (MAX_TASKS - i));
         offer(KIND_LOAD, fields);
      end
      offer(KIND_START, random_task());

      // random batches under three idling patterns
      for (int phase = 0; phase < 3; phase++) begin
         counted     = 0;
         tx_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 88 : 0;
         rx_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 21 : 0;
         if (phase > 0) drain_results();
         if (phase == 2) long_hold_go = 1'b1;
         while (counted < PHASE_ITEMS) begin
            case ($urandom_range(0, 19))
               0:          batch = 0;
               1, 2:       batch = $urandom_range(MAX_TASKS + 1, MAX_TASKS + 4);
               3, 4, 5, 6: batch = $urandom_range(7, MAX_TASKS);
               default:    batch = $urandom_range(1, 6);
            endcase
            for (int i = 0; i < batch; i++) offer(KIND_LOAD, random_task());
            offer(KIND_START, random_task());
            counted += ((batch < MAX_TASKS) ? batch : MAX_TASKS) + 1;
         end
      end

      // let the last run finish and settle
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   // Result side: random stalls, or one long hold-off on request
   initial begin : receiver
      int held;
      forever begin
         @(posedge clock);
         if (long_hold_go) begin
            long_hold_go = 1'b0;
            rsp_tready <= 1'b0;
            for (held = 0; held < LONG_HOLD; held++) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   // End the run if it hangs
   initial begin : watchdog
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

endmodule
